### rtl/gnnt_pkg.sv
// shared types, constants and microcode table for the greedy nearest-neighbor tour unit
// no dependencies
package gnnt_pkg;

  localparam int unsigned MaxNodesDefault = 8;
  localparam int unsigned WeightWidth     = 16;
  localparam int unsigned CostWidth       = 19;
  localparam int unsigned OutVertexWidth  = 3;
  localparam int unsigned NodeCountWidth  = 4;
  localparam int unsigned StartNodeWidth  = 3;
  localparam int unsigned CfgIndexWidth   = 2;
  localparam int unsigned CfgDataWidth    = 4;

  localparam logic [CostWidth-1:0] CostMax = '1;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_START_NODE = 2'd1;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  // micro-operations
  typedef enum logic [2:0] {
    U_ACCEPT,
    U_CHKSTART,
    U_SCAN,
    U_DRAIN,
    U_STEP,
    U_BACK,
    U_CLOSE,
    U_EMIT
  } uop_e;

  localparam int unsigned StepWidth = 3;
  typedef logic [StepWidth-1:0] step_t;

  localparam step_t S_ACCEPT   = 3'd0;
  localparam step_t S_CHKSTART = 3'd1;
  localparam step_t S_SCAN     = 3'd2;
  localparam step_t S_DRAIN    = 3'd3;
  localparam step_t S_STEP     = 3'd4;
  localparam step_t S_BACK     = 3'd5;
  localparam step_t S_CLOSE    = 3'd6;
  localparam step_t S_EMIT     = 3'd7;

  typedef struct packed {
    uop_e  op;
    step_t jump;
  } ucode_t;

  // control store: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      S_ACCEPT:   w = '{op: U_ACCEPT,   jump: S_ACCEPT};
      S_CHKSTART: w = '{op: U_CHKSTART, jump: S_EMIT};
      S_SCAN:     w = '{op: U_SCAN,     jump: S_SCAN};
      S_DRAIN:    w = '{op: U_DRAIN,    jump: S_STEP};
      S_STEP:     w = '{op: U_STEP,     jump: S_SCAN};
      S_BACK:     w = '{op: U_BACK,     jump: S_CLOSE};
      S_CLOSE:    w = '{op: U_CLOSE,    jump: S_EMIT};
      S_EMIT:     w = '{op: U_EMIT,     jump: S_ACCEPT};
      default:    w = '{op: U_ACCEPT,   jump: S_ACCEPT};
    endcase
    return w;
  endfunction

  // saturating cost accumulate
  function automatic logic [CostWidth-1:0] sat_add(logic [CostWidth-1:0] a,
                                                   logic [WeightWidth-1:0] b);
    logic [CostWidth:0] s;
    s = {1'b0, a} + (CostWidth+1)'(b);
    return s[CostWidth] ? CostMax : s[CostWidth-1:0];
  endfunction

endpackage

### rtl/gnnt_wram.sv
// weight store: one write port, one read port with registered read data
// uses gnnt_pkg for the weight width
module gnnt_wram #(
  parameter int unsigned AddrWidth = 6
) (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [AddrWidth-1:0]               wr_addr_i,
  input  logic [gnnt_pkg::WeightWidth-1:0]   wr_data_i,
  input  logic                               rd_en_i,
  input  logic [AddrWidth-1:0]               rd_addr_i,
  output logic [gnnt_pkg::WeightWidth-1:0]   rd_data_o
);

  logic [gnnt_pkg::WeightWidth-1:0] mem_q [2**AddrWidth];
  logic [gnnt_pkg::WeightWidth-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/greedy_nearest_neighbor_tour_unit.sv
// greedy nearest-neighbor tour unit: weight store, microcoded sequencer and scan datapath
// depends on gnnt_pkg and gnnt_wram
// load item: writes one weight when row and column are in range, no result
// run item: one row scan per scanned row, R scanned rows (R = path length, at most n);
//   the weight store read port scans one row entry per cycle
// results stream out as the walk advances; the last result follows the return-edge read
// async active-low reset: node_count 8, start_node 0, sequencer idle, no result pending
module greedy_nearest_neighbor_tour_unit #(
  parameter int unsigned MaxNodes = gnnt_pkg::MaxNodesDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [gnnt_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [gnnt_pkg::CfgDataWidth-1:0]      cfg_data_i,
  // input item channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   func_i,
  input  logic [2:0]                             row_i,
  input  logic [2:0]                             col_i,
  input  logic [gnnt_pkg::WeightWidth-1:0]       weight_i,
  // result item channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [gnnt_pkg::OutVertexWidth-1:0]    vertex_o,
  output logic                                   is_last_o,
  output logic                                   found_o,
  output logic [gnnt_pkg::CostWidth-1:0]         total_cost_o
);

  // vertex index width, row/col address width, path length width
  localparam int unsigned VW = $clog2(MaxNodes);
  localparam int unsigned AW = 2 * VW;
  localparam int unsigned LW = $clog2(MaxNodes + 1);

  // configuration registers
  logic [gnnt_pkg::NodeCountWidth-1:0] node_count_q;
  logic [gnnt_pkg::StartNodeWidth-1:0] start_node_q;

  // sequencer and datapath state
  gnnt_pkg::step_t                  step_q, step_d;
  gnnt_pkg::ucode_t                 uw;
  logic [VW-1:0]                    cur_q;
  logic [VW-1:0]                    idx_q;
  logic [VW-1:0]                    rd_idx_q;
  logic                             rd_v_q;
  logic [MaxNodes-1:0]              visited_q;
  logic                             have_q;
  logic [VW-1:0]                    best_q;
  logic [gnnt_pkg::WeightWidth-1:0] best_w_q;
  logic [gnnt_pkg::CostWidth-1:0]   cost_q;
  logic [LW-1:0]                    len_q;
  logic                             bad_q;
  logic                             found_q;
  logic [gnnt_pkg::CostWidth-1:0]   tot_q;

  // output register
  logic                                out_valid_q;
  logic [gnnt_pkg::OutVertexWidth-1:0] out_vertex_q;
  logic                                out_last_q;
  logic                                out_found_q;
  logic [gnnt_pkg::CostWidth-1:0]      out_cost_q;

  // weight store ports
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic [gnnt_pkg::WeightWidth-1:0] rd_data;

  // decoded control
  logic          in_acc;
  logic          out_free;
  logic [LW-1:0] eff_n;
  logic          start_bad;
  logic [VW-1:0] start_v;
  logic          scan_last;
  logic          can_adv;
  logic          cand;
  logic          emit_mid;
  logic          emit_last;
  logic          row_ok;
  logic          col_ok;

  // node count above the store size acts as the store size
  always_comb begin
    if (32'(node_count_q) > 32'(MaxNodes)) begin
      eff_n = LW'(MaxNodes);
    end else begin
      eff_n = LW'(node_count_q);
    end
  end

  assign start_bad = 32'(start_node_q) >= 32'(eff_n);
  assign start_v   = VW'(start_node_q);

  assign uw          = gnnt_pkg::ucode_rom(step_q);
  assign in_ready_o  = (uw.op == gnnt_pkg::U_ACCEPT);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // scan issues entry idx while judging the entry read in the cycle before
  assign scan_last = (32'(idx_q) + 32'd1) >= 32'(eff_n);
  assign can_adv   = have_q && (32'(len_q) < 32'(MaxNodes));
  assign cand      = rd_v_q && (rd_data != '0) && !visited_q[rd_idx_q] &&
                     (!have_q || (rd_data < best_w_q));

  assign emit_mid  = (uw.op == gnnt_pkg::U_STEP) && can_adv && out_free;
  assign emit_last = (uw.op == gnnt_pkg::U_EMIT) && out_free;

  // writes outside the store are dropped
  assign row_ok  = 32'(row_i) < 32'(MaxNodes);
  assign col_ok  = 32'(col_i) < 32'(MaxNodes);
  assign wr_en   = in_acc && (func_i == gnnt_pkg::FUNC_LOAD) && row_ok && col_ok;
  assign wr_addr = {VW'(row_i), VW'(col_i)};

  // row of the current vertex during scan, return edge during back
  assign rd_en   = (uw.op == gnnt_pkg::U_SCAN) || (uw.op == gnnt_pkg::U_BACK);
  assign rd_addr = {cur_q, (uw.op == gnnt_pkg::U_BACK) ? start_v : idx_q};

  // next step: fall through, hold, or take the word's jump on its condition
  always_comb begin
    unique case (uw.op)
      gnnt_pkg::U_ACCEPT: begin
        if (in_acc && (func_i == gnnt_pkg::FUNC_RUN)) begin
          step_d = step_q + gnnt_pkg::StepWidth'(1);
        end else begin
          step_d = uw.jump;
        end
      end
      gnnt_pkg::U_CHKSTART: begin
        step_d = bad_q ? uw.jump : step_q + gnnt_pkg::StepWidth'(1);
      end
      gnnt_pkg::U_SCAN: begin
        step_d = scan_last ? step_q + gnnt_pkg::StepWidth'(1) : uw.jump;
      end
      gnnt_pkg::U_STEP: begin
        if (can_adv) begin
          step_d = out_free ? uw.jump : step_q;
        end else begin
          step_d = step_q + gnnt_pkg::StepWidth'(1);
        end
      end
      gnnt_pkg::U_EMIT: begin
        step_d = out_free ? uw.jump : step_q;
      end
      gnnt_pkg::U_DRAIN, gnnt_pkg::U_BACK, gnnt_pkg::U_CLOSE: begin
        step_d = uw.jump;
      end
      default: begin
        step_d = gnnt_pkg::S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gnnt_pkg::NodeCountWidth'(8);
      start_node_q <= '0;
      step_q       <= gnnt_pkg::S_ACCEPT;
      cur_q        <= '0;
      idx_q        <= '0;
      rd_idx_q     <= '0;
      rd_v_q       <= 1'b0;
      visited_q    <= '0;
      have_q       <= 1'b0;
      best_q       <= '0;
      best_w_q     <= '0;
      cost_q       <= '0;
      len_q        <= '0;
      bad_q        <= 1'b0;
      found_q      <= 1'b0;
      tot_q        <= '0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_last_q   <= 1'b0;
      out_found_q  <= 1'b0;
      out_cost_q   <= '0;
    end else begin
      step_q <= step_d;

      // configuration writes, unknown indexes ignored
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          gnnt_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[gnnt_pkg::NodeCountWidth-1:0];
          gnnt_pkg::CFG_START_NODE: start_node_q <= cfg_data_i[gnnt_pkg::StartNodeWidth-1:0];
          default: ;
        endcase
      end

      // result register drains when taken and nothing new replaces it
      if (out_valid_q && out_ready_i && !emit_mid && !emit_last) begin
        out_valid_q <= 1'b0;
      end

      unique case (uw.op)
        gnnt_pkg::U_ACCEPT: begin
          if (in_acc && (func_i == gnnt_pkg::FUNC_RUN)) begin
            // run start: clear walk state, mark start when in range
            visited_q <= start_bad ? '0 : (MaxNodes'(1) << start_v);
            cur_q   <= start_v;
            idx_q   <= '0;
            rd_v_q  <= 1'b0;
            have_q  <= 1'b0;
            cost_q  <= '0;
            len_q   <= LW'(1);
            bad_q   <= start_bad;
            found_q <= 1'b0;
            tot_q   <= '0;
          end
        end
        gnnt_pkg::U_CHKSTART: ;
        gnnt_pkg::U_SCAN: begin
          rd_idx_q <= idx_q;
          rd_v_q   <= 1'b1;
          idx_q    <= idx_q + VW'(1);
          if (cand) begin
            have_q   <= 1'b1;
            best_q   <= rd_idx_q;
            best_w_q <= rd_data;
          end
        end
        gnnt_pkg::U_DRAIN: begin
          rd_v_q <= 1'b0;
          if (cand) begin
            have_q   <= 1'b1;
            best_q   <= rd_idx_q;
            best_w_q <= rd_data;
          end
        end
        gnnt_pkg::U_STEP: begin
          if (emit_mid) begin
            // current vertex is not the last one: send it and move on
            out_valid_q       <= 1'b1;
            out_vertex_q      <= gnnt_pkg::OutVertexWidth'(cur_q);
            out_last_q        <= 1'b0;
            out_found_q       <= 1'b0;
            out_cost_q        <= '0;
            cur_q             <= best_q;
            visited_q[best_q] <= 1'b1;
            cost_q            <= gnnt_pkg::sat_add(cost_q, best_w_q);
            len_q             <= len_q + LW'(1);
            have_q            <= 1'b0;
            idx_q             <= '0;
          end
        end
        gnnt_pkg::U_BACK: ;
        gnnt_pkg::U_CLOSE: begin
          // closed tour needs every vertex and an edge back to start
          if ((32'(len_q) >= 32'(eff_n)) && (rd_data != '0)) begin
            found_q <= 1'b1;
            tot_q   <= gnnt_pkg::sat_add(cost_q, rd_data);
          end
        end
        gnnt_pkg::U_EMIT: begin
          if (emit_last) begin
            out_valid_q  <= 1'b1;
            out_vertex_q <= bad_q ? gnnt_pkg::OutVertexWidth'(start_node_q)
                                  : gnnt_pkg::OutVertexWidth'(cur_q);
            out_last_q   <= 1'b1;
            out_found_q  <= found_q;
            out_cost_q   <= tot_q;
          end
        end
        default: ;
      endcase
    end
  end

  gnnt_wram #(
    .AddrWidth (AW)
  ) u_wram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (weight_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign vertex_o     = out_vertex_q;
  assign is_last_o    = out_last_q;
  assign found_o      = out_found_q;
  assign total_cost_o = out_cost_q;

  // intermediate path vertices carry no tour status
  a_mid_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_last_o) |-> (!found_o && (total_cost_o == '0)))
    else $error("intermediate result carries tour status");

  // the walk never records more vertices than the store holds
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= 32'(MaxNodes))
    else $error("path length beyond vertex count");

  // a found tour always covers every vertex in use
  a_found_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((uw.op == gnnt_pkg::U_EMIT) && found_q) |-> (32'(len_q) >= 32'(eff_n)))
    else $error("tour reported found with vertices left");

  // the vertex whose row is scanned is already marked visited
  a_cur_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == gnnt_pkg::U_SCAN) |-> visited_q[cur_q])
    else $error("scanning from an unmarked vertex");

  // a mid-path result is only sent when the walk really advances
  a_adv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_mid |=> (len_q == $past(len_q) + LW'(1)))
    else $error("path length did not advance with result");

endmodule

### sim/greedy_nearest_neighbor_tour_unit_tb.sv
// self-checking testbench for the greedy nearest-neighbor tour unit
// depends on gnnt_pkg and greedy_nearest_neighbor_tour_unit (with its weight ram)
// directed corner runs, then randomized weight loads and tour runs under back-pressure
module greedy_nearest_neighbor_tour_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NodeSlots   = gnnt_pkg::MaxNodesDefault;
  localparam int unsigned CostCeil    = (1 << gnnt_pkg::CostWidth) - 1;
  // settle wait long enough to cover a run still busy at eight nodes
  localparam int unsigned RunSettle   = 120;
  localparam int unsigned RandomItems = 240;
  localparam int unsigned CycleLimit  = 500000;
  // index that decodes to no register, writes to it must change nothing
  localparam logic [gnnt_pkg::CfgIndexWidth-1:0] CFG_SPARE = 2'd3;

  // one expected result item of a tour run
  typedef struct packed {
    logic [gnnt_pkg::OutVertexWidth-1:0] vertex;
    logic                                is_last;
    logic                                found;
    logic [gnnt_pkg::CostWidth-1:0]      cost;
  } tour_step_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SLOW,
    SINK_BEAT
  } sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [gnnt_pkg::CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [gnnt_pkg::CfgDataWidth-1:0]  cfg_data_i  = '0;

  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic                             func_i     = gnnt_pkg::FUNC_LOAD;
  logic [2:0]                       row_i      = '0;
  logic [2:0]                       col_i      = '0;
  logic [gnnt_pkg::WeightWidth-1:0] weight_i   = '0;

  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [gnnt_pkg::OutVertexWidth-1:0] vertex_o;
  logic                                is_last_o;
  logic                                found_o;
  logic [gnnt_pkg::CostWidth-1:0]      total_cost_o;

  // shadow of the block: weight matrix and both registers
  logic [gnnt_pkg::WeightWidth-1:0]    wt_mem [NodeSlots*NodeSlots];
  logic [gnnt_pkg::NodeCountWidth-1:0] nodes_cfg = 4'd8;
  logic [gnnt_pkg::StartNodeWidth-1:0] start_cfg = 3'd0;

  // results still owed by the block, oldest first
  tour_step_t tour_q [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // sender pacing
  bit          pace_bursts = 1'b0;
  int unsigned burst_left  = 0;

  // receiver pacing
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_hold = 0;

  greedy_nearest_neighbor_tour_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .row_i,
    .col_i,
    .weight_i,
    .out_valid_o,
    .out_ready_i,
    .vertex_o,
    .is_last_o,
    .found_o,
    .total_cost_o
  );

  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: each style holds for a random stretch, open stretches included
  always @(posedge clk_i) begin
    if (sink_hold == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 3));
      sink_hold <= $urandom_range(16, 160);
    end else begin
      sink_hold <= sink_hold - 1;
    end
    case (sink_mode)
      SINK_OPEN: out_ready_i <= 1'b1;
      SINK_COIN: out_ready_i <= 1'($urandom_range(0, 1));
      SINK_SLOW: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (cycle_count % 3 != 0);
    endcase
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // compare every accepted result item with the oldest expectation
  always @(posedge clk_i) begin
    tour_step_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tour_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, vertex %0d", vertex_o));
      end else begin
        want = tour_q.pop_front();
        if (vertex_o !== want.vertex) begin
          flag_mismatch($sformatf("vertex %0d, expected %0d", vertex_o, want.vertex));
        end
        if (is_last_o !== want.is_last) begin
          flag_mismatch($sformatf("is_last %0b, expected %0b", is_last_o, want.is_last));
        end
        if (found_o !== want.found) begin
          flag_mismatch($sformatf("found %0b, expected %0b", found_o, want.found));
        end
        if (total_cost_o !== want.cost) begin
          flag_mismatch($sformatf("total_cost %0d, expected %0d", total_cost_o, want.cost));
        end
      end
    end
  end

  function automatic int unsigned cost_add(input int unsigned acc, input int unsigned w);
    return (acc + w > CostCeil) ? CostCeil : acc + w;
  endfunction

  // greedy walk on the shadow matrix, queues one expectation per path vertex
  function automatic void walk_tour();
    int unsigned                      n_eff;
    int unsigned                      len;
    int unsigned                      sum;
    int unsigned                      total;
    logic [NodeSlots-1:0]             seen;
    logic [2:0]                       path [NodeSlots];
    logic [2:0]                       here;
    logic [2:0]                       best;
    logic [gnnt_pkg::WeightWidth-1:0] w;
    logic [gnnt_pkg::WeightWidth-1:0] best_w;
    logic [gnnt_pkg::WeightWidth-1:0] back;
    bit                               have;
    bit                               closed;
    tour_step_t                       step;
    // node counts above the store size act as the full store
    n_eff = (nodes_cfg > NodeSlots) ? NodeSlots : nodes_cfg;
    // start outside the graph: start vertex alone, never found
    if (start_cfg >= n_eff) begin
      step.vertex  = start_cfg;
      step.is_last = 1'b1;
      step.found   = 1'b0;
      step.cost    = '0;
      tour_q.push_back(step);
      return;
    end
    seen            = '0;
    seen[start_cfg] = 1'b1;
    path[0]         = start_cfg;
    len             = 1;
    here            = start_cfg;
    sum             = 0;
    do begin
      have   = 1'b0;
      best   = '0;
      best_w = '0;
      // strict less-than keeps the lower index on a tie, zero is no edge
      for (int unsigned i = 0; i < n_eff; i++) begin
        w = wt_mem[here * NodeSlots + i];
        if (w != 0 && !seen[i] && (!have || w < best_w)) begin
          have   = 1'b1;
          best   = 3'(i);
          best_w = w;
        end
      end
      if (have && len < NodeSlots) begin
        seen[best] = 1'b1;
        path[len]  = best;
        len++;
        sum  = cost_add(sum, best_w);
        here = best;
      end
    end while (have && len < NodeSlots);
    // closed only when every vertex is on the path and an edge leads home
    closed = 1'b0;
    total  = 0;
    if (len >= n_eff) begin
      back = wt_mem[here * NodeSlots + start_cfg];
      if (back != 0) begin
        closed = 1'b1;
        total  = cost_add(sum, back);
      end
    end
    for (int unsigned i = 0; i < len; i++) begin
      step.vertex  = path[i];
      step.is_last = (i + 1 == len);
      step.found   = step.is_last ? closed : 1'b0;
      step.cost    = step.is_last ? gnnt_pkg::CostWidth'(total) : '0;
      tour_q.push_back(step);
    end
  endfunction

  // one item on the input channel, bursts and gaps when pacing is on
  task automatic send_item(input logic func, input logic [2:0] row, input logic [2:0] col,
                           input logic [gnnt_pkg::WeightWidth-1:0] weight);
    if (pace_bursts) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    row_i      <= row;
    col_i      <= col;
    weight_i   <= weight;
    do @(posedge clk_i); while (!in_ready_o);
    // item taken at this edge, predict in acceptance order
    if (func == gnnt_pkg::FUNC_LOAD) begin
      wt_mem[row * NodeSlots + col] = weight;
    end else begin
      walk_tour();
    end
  endtask

  task automatic load_weight(input logic [2:0] row, input logic [2:0] col,
                             input logic [gnnt_pkg::WeightWidth-1:0] weight);
    send_item(gnnt_pkg::FUNC_LOAD, row, col, weight);
  endtask

  // payload fields other than func are don't-care on a run, keep them toggling
  task automatic run_tour();
    send_item(gnnt_pkg::FUNC_RUN, 3'($urandom), 3'($urandom),
              gnnt_pkg::WeightWidth'($urandom));
  endtask

  // hold the sender until every owed result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tour_q.size() != 0);
  endtask

  // register writes only with the block idle
  task automatic write_reg(input logic [gnnt_pkg::CfgIndexWidth-1:0] idx,
                           input logic [gnnt_pkg::CfgDataWidth-1:0] data);
    drain_results();
    repeat (RunSettle) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == gnnt_pkg::CFG_NODE_COUNT) begin
      nodes_cfg = data;
    end else if (idx == gnnt_pkg::CFG_START_NODE) begin
      start_cfg = data[gnnt_pkg::StartNodeWidth-1:0];
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly nonzero weights, small values for ties, some extremes
  function automatic logic [gnnt_pkg::WeightWidth-1:0] pick_weight();
    case ($urandom_range(0, 19))
      0, 1, 2:       return '0;
      3:             return '1;
      4:             return 16'd1;
      5, 6, 7, 8, 9: return gnnt_pkg::WeightWidth'($urandom_range(1, 4));
      default:       return gnnt_pkg::WeightWidth'($urandom);
    endcase
  endfunction

  // write every entry so no run can read an unwritten weight, then one run at reset settings
  task automatic test_store_fill();
    for (int unsigned r = 0; r < NodeSlots; r++) begin
      for (int unsigned c = 0; c < NodeSlots; c++) begin
        load_weight(3'(r), 3'(c), pick_weight());
      end
    end
    run_tour();
  endtask

  // tie broken toward the lower index, zero skipped, widest weight, open and dead-end walks
  task automatic test_tie_and_gap_edges();
    write_reg(gnnt_pkg::CFG_NODE_COUNT, 4'd4);
    write_reg(gnnt_pkg::CFG_START_NODE, 4'd1);
    load_weight(3'd1, 3'd0, 16'd7);
    load_weight(3'd1, 3'd2, 16'd7);
    load_weight(3'd1, 3'd3, 16'd0);
    load_weight(3'd0, 3'd2, 16'd0);
    load_weight(3'd0, 3'd3, 16'hFFFF);
    load_weight(3'd3, 3'd2, 16'd1);
    load_weight(3'd2, 3'd1, 16'd3);
    run_tour();
    // all vertices visited but no way home
    load_weight(3'd2, 3'd1, 16'd0);
    run_tour();
    // walk stalls at vertex 0
    load_weight(3'd0, 3'd3, 16'd0);
    run_tour();
  endtask

  // smallest graph, single vertex, empty graph, start outside, oversized count
  task automatic test_corner_settings();
    write_reg(gnnt_pkg::CFG_NODE_COUNT, 4'd2);
    write_reg(gnnt_pkg::CFG_START_NODE, 4'd1);
    run_tour();
    write_reg(gnnt_pkg::CFG_NODE_COUNT, 4'd1);
    write_reg(gnnt_pkg::CFG_START_NODE, 4'd0);
    load_weight(3'd0, 3'd0, 16'h1234);
    run_tour();
    load_weight(3'd0, 3'd0, 16'd0);
    run_tour();
    write_reg(gnnt_pkg::CFG_NODE_COUNT, 4'd0);
    run_tour();
    write_reg(gnnt_pkg::CFG_NODE_COUNT, 4'd3);
    write_reg(gnnt_pkg::CFG_START_NODE, 4'd13);
    run_tour();
    write_reg(CFG_SPARE, 4'hF);
    run_tour();
    write_reg(gnnt_pkg::CFG_NODE_COUNT, 4'd15);
    write_reg(gnnt_pkg::CFG_START_NODE, 4'd7);
    run_tour();
  endtask

  // phases of random settings, each a batch of weight loads and runs
  task automatic test_random_traffic();
    int unsigned                         sent;
    int unsigned                         phase;
    int unsigned                         batch;
    int unsigned                         n_eff;
    logic [gnnt_pkg::NodeCountWidth-1:0] n_sel;
    logic [gnnt_pkg::StartNodeWidth-1:0] s_sel;
    logic [2:0]                          row;
    logic [2:0]                          col;
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      // first two phases pin the largest and smallest graphs
      if (phase == 0) begin
        n_sel = 4'd8;
      end else if (phase == 1) begin
        n_sel = 4'd2;
      end else if ($urandom_range(0, 3) != 0) begin
        n_sel = gnnt_pkg::NodeCountWidth'($urandom_range(2, 8));
      end else if ($urandom_range(0, 1) == 0) begin
        n_sel = gnnt_pkg::NodeCountWidth'($urandom_range(0, 1));
      end else begin
        n_sel = gnnt_pkg::NodeCountWidth'($urandom_range(9, 15));
      end
      n_eff = (n_sel > NodeSlots) ? NodeSlots : n_sel;
      if (phase == 0) begin
        s_sel = 3'd7;
      end else if (phase == 1) begin
        s_sel = 3'd0;
      end else if (n_eff > 0 && $urandom_range(0, 4) != 0) begin
        s_sel = 3'($urandom_range(0, n_eff - 1));
      end else begin
        s_sel = 3'($urandom);
      end
      write_reg(gnnt_pkg::CFG_NODE_COUNT, n_sel);
      // upper data bit is outside the start field and must be dropped
      write_reg(gnnt_pkg::CFG_START_NODE, {1'($urandom), s_sel});
      pace_bursts = ($urandom_range(0, 3) != 0);
      batch       = $urandom_range(15, 40);
      for (int unsigned k = 0; k < batch; k++) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 9) == 0) begin
            drain_results();
          end
          run_tour();
        end else begin
          // loads mostly land inside the graph in use
          if (n_eff > 0 && $urandom_range(0, 4) != 0) begin
            row = 3'($urandom_range(0, n_eff - 1));
            col = 3'($urandom_range(0, n_eff - 1));
          end else begin
            row = 3'($urandom);
            col = 3'($urandom);
          end
          load_weight(row, col, pick_weight());
        end
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_store_fill();
    test_tie_and_gap_edges();
    test_corner_settings();
    test_random_traffic();
    // let the last run drain and watch for stray results
    drain_results();
    repeat (RunSettle) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
